// ===== hw/rtl/ptsc_pkg.sv =====
`timescale 1ns / 1ps
package ptsc_pkg;
    localparam int CordicStepsDefault = 16;
    localparam int TabLen = 24;
    localparam int InW = 24;
    localparam int DiffW = 25;
    // vector datapath: difference * 2^24, plus CORDIC growth headroom
    localparam int VecW = 52;
    localparam int AngW = 34;
    localparam int SqW = 51;
    localparam int RootW = 26;
    localparam int ColW = 16;
    localparam int DistW = 25;
    localparam int SwW = 12;
    localparam int CprW = 20;
    localparam int CfgIdxW = 1;
    localparam int CfgDataW = 20;
    localparam logic [CfgIdxW-1:0] CfgScreenWidth = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgColsPerRadian = 1'd1;
    localparam logic [SwW-1:0] SwReset = 12'd320;
    localparam logic [CprW-1:0] CprReset = 20'd78234;
    localparam logic signed [AngW-1:0] Pi30 = 34'sd3373259426;
    localparam logic signed [AngW-1:0] TwoPi30 = 34'sd6746518852;
    localparam logic signed [AngW-1:0] HalfPi30 = 34'sd1686629713;
    localparam logic signed [15:0] Pi13 = 16'sd25736;
    localparam logic signed [16:0] TwoPi13 = 17'sd51472;

    function automatic logic signed [AngW-1:0] atan_tab(input int i);
        logic signed [AngW-1:0] r;
        case (i)
            0: r = 34'sd843314856;
            1: r = 34'sd497837829;
            2: r = 34'sd263043836;
            3: r = 34'sd133525158;
            4: r = 34'sd67021686;
            5: r = 34'sd33543515;
            6: r = 34'sd16775850;
            7: r = 34'sd8388437;
            8: r = 34'sd4194282;
            9: r = 34'sd2097149;
            10: r = 34'sd1048575;
            11: r = 34'sd524287;
            12: r = 34'sd262143;
            13: r = 34'sd131071;
            14: r = 34'sd65535;
            15: r = 34'sd32767;
            16: r = 34'sd16383;
            17: r = 34'sd8191;
            18: r = 34'sd4095;
            19: r = 34'sd2047;
            20: r = 34'sd1023;
            21: r = 34'sd511;
            22: r = 34'sd255;
            23: r = 34'sd127;
            default: r = '0;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic signed [VecW-1:0] x;
        logic signed [VecW-1:0] y;
        logic signed [AngW-1:0] z;
        logic                   zero;
    } cordic_t;

    typedef struct packed {
        logic [SqW-1:0]   rem;
        logic [RootW-1:0] root;
    } sqrt_t;
endpackage

// ===== hw/rtl/ptsc_cordic_stage.sv =====
`timescale 1ns / 1ps
module ptsc_cordic_stage
    import ptsc_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  cordic_t cin,
    output cordic_t cout
);
    logic signed [VecW-1:0] xs;
    logic signed [VecW-1:0] ys;

    always_comb
    begin
        xs = cin.x >>> STEP;
        ys = cin.y >>> STEP;
        cout = cin;
        if (!cin.zero)
        begin
            if (cin.y >= 0)
            begin
                cout.x = cin.x + ys;
                cout.y = cin.y - xs;
                cout.z = cin.z + atan_tab(STEP);
            end
            else
            begin
                cout.x = cin.x - ys;
                cout.y = cin.y + xs;
                cout.z = cin.z - atan_tab(STEP);
            end
        end
    end
endmodule

// ===== hw/rtl/ptsc_sqrt_stage.sv =====
`timescale 1ns / 1ps
module ptsc_sqrt_stage
    import ptsc_pkg::*;
#(
    parameter int BITPOS = 0
)
(
    input  sqrt_t sin,
    output sqrt_t sout
);
    // one result bit: trial root with this bit set, compared to the remainder
    logic [SqW:0] trial;

    always_comb
    begin
        trial = ({1'b0, {(SqW - RootW){1'b0}}, sin.root} << (BITPOS + 1))
                + ((SqW + 1)'(1) << (2 * BITPOS));
        sout = sin;
        if ({1'b0, sin.rem} >= trial)
        begin
            sout.rem = sin.rem - trial[SqW-1:0];
            sout.root = sin.root | (RootW'(1) << BITPOS);
        end
    end
endmodule

// ===== hw/rtl/point_to_screen_column_projection.sv =====
`timescale 1ns / 1ps
// Point-to-screen-column projection.
// s_axis carries one point per transaction: point, viewer position and heading
// (six signed Q12.12 values). m_axis returns the screen column (signed, rounded,
// saturated) and the viewer-to-point distance (unsigned Q13.12).
// screen_width (index 0) and cols_per_radian (index 1) are written via cfg_we,
// cfg_index, cfg_data, by the user only while the block is idle (not enforced).
// Throughput: one transaction per cycle while the output is not stalled. The
// unrolled CORDIC chain does one micro-rotation per stage; the root extraction
// runs beside it, SQ_PER result bits per stage (two with the default steps).
// Reset clears every valid bit and restores the register defaults.
// When the output register is full and m_axis_tready is low, the whole pipeline
// holds; s_axis_tready drops only then, so nothing is lost or repeated.
module point_to_screen_column_projection
    import ptsc_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDefault
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // point_x, point_y, viewer_x, viewer_y, heading_x, heading_y
    input  logic [143:0]         s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // column[15:0], distance[40:16], zero pad
    output logic [47:0]          m_axis_tdata,
    input  logic                 cfg_we,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);
    localparam int NSTEP = (CORDIC_STEPS < TabLen) ? CORDIC_STEPS : TabLen;
    // total pipeline depth: prerotation + NSTEP + 4 post stages
    localparam int DEPTH = NSTEP + 5;
    localparam int SQ_PER = (RootW + NSTEP - 1) / NSTEP;

    logic [SwW-1:0]  screen_width_reg;
    logic [CprW-1:0] cols_per_radian_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg <= SwReset;
            cols_per_radian_reg <= CprReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CfgScreenWidth:   screen_width_reg <= cfg_data[SwW-1:0];
                CfgColsPerRadian: cols_per_radian_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [DEPTH-1:0] vld_reg;
    logic adv;
    assign adv = m_axis_tready || !vld_reg[DEPTH-1];
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
    end

    // stage 0: differences, prerotation, squares
    logic signed [InW-1:0] px, py, vx, vy, hx, hy;
    logic signed [DiffW-1:0] dx, dy;
    cordic_t pre_p, pre_h;

    assign px = s_axis_tdata[23:0];
    assign py = s_axis_tdata[47:24];
    assign vx = s_axis_tdata[71:48];
    assign vy = s_axis_tdata[95:72];
    assign hx = s_axis_tdata[119:96];
    assign hy = s_axis_tdata[143:120];
    assign dx = DiffW'(px) - DiffW'(vx);
    assign dy = DiffW'(py) - DiffW'(vy);

    function automatic cordic_t prerot(input logic signed [DiffW-1:0] y,
                                       input logic signed [DiffW-1:0] x);
        cordic_t c;
        logic signed [VecW-1:0] xe, ye;
        xe = VecW'(x) <<< 24;
        ye = VecW'(y) <<< 24;
        c.zero = (x == 0) && (y == 0);
        c.x = xe;
        c.y = ye;
        c.z = '0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                c.x = ye; c.y = -xe; c.z = HalfPi30;
            end
            else
            begin
                c.x = -ye; c.y = xe; c.z = -HalfPi30;
            end
        end
        return c;
    endfunction

    assign pre_p = prerot(dy, dx);
    assign pre_h = prerot(DiffW'(hy), DiffW'(hx));

    cordic_t cp_reg [NSTEP+1];
    cordic_t ch_reg [NSTEP+1];
    sqrt_t   sq_reg [1:NSTEP];
    logic [2*DiffW-1:0] dxx_reg, dyy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cp_reg[0] <= pre_p;
            ch_reg[0] <= pre_h;
            dxx_reg <= $unsigned((2*DiffW)'(dx) * (2*DiffW)'(dx));
            dyy_reg <= $unsigned((2*DiffW)'(dy) * (2*DiffW)'(dy));
        end
    end

    // stage 1 (shares cp_reg index 0 -> 1 chain): sum of squares
    sqrt_t sq_reg_in;
    always_comb
    begin
        sq_reg_in.rem = SqW'(dxx_reg) + SqW'(dyy_reg);
        sq_reg_in.root = '0;
    end

    genvar g;
    generate
        for (g = 0; g < NSTEP; g++)
        begin : g_cordic
            cordic_t np, nh;
            sqrt_t ns [SQ_PER+1];
            ptsc_cordic_stage #(.STEP(g)) u_p (.cin(cp_reg[g]), .cout(np));
            ptsc_cordic_stage #(.STEP(g)) u_h (.cin(ch_reg[g]), .cout(nh));
            if (g == 0)
            begin : g_first
                assign ns[0] = sq_reg_in;
            end
            else
            begin : g_next
                assign ns[0] = sq_reg[g];
            end
            for (genvar k = 0; k < SQ_PER; k++)
            begin : g_sq
                localparam int BP = RootW - 1 - g * SQ_PER - k;
                if (BP >= 0)
                begin : g_on
                    ptsc_sqrt_stage #(.BITPOS(BP)) u_s (.sin(ns[k]), .sout(ns[k+1]));
                end
                else
                begin : g_off
                    assign ns[k+1] = ns[k];
                end
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    cp_reg[g+1] <= np;
                    ch_reg[g+1] <= nh;
                    sq_reg[g+1] <= ns[SQ_PER];
                end
            end
        end
    endgenerate

    // post stage A: angle difference, wrap; rounded distance
    logic signed [AngW+1:0] ad;
    logic signed [AngW+1:0] aw_reg;
    logic [DistW-1:0] dist_a_reg;
    logic [RootW:0] rnd;
    always_comb
    begin
        ad = (AngW+2)'(cp_reg[NSTEP].z) - (AngW+2)'(ch_reg[NSTEP].z);
        if (ad > (AngW+2)'(Pi30)) ad = ad - (AngW+2)'(TwoPi30);
        if (ad <= -(AngW+2)'(Pi30)) ad = ad + (AngW+2)'(TwoPi30);
        rnd = {1'b0, sq_reg[NSTEP].root}
              + ((SqW'(sq_reg[NSTEP].rem) > SqW'(sq_reg[NSTEP].root)) ? 1'b1 : 1'b0);
    end

    // post stage B: round to Q3.13 and fix branch
    logic [AngW+1:0] amag;
    logic [AngW+1:0] amr;
    logic signed [17:0] a13;
    logic signed [17:0] a13_reg;
    logic [DistW-1:0] dist_b_reg;
    always_comb
    begin
        amag = aw_reg[AngW+1] ? $unsigned(-aw_reg) : $unsigned(aw_reg);
        amr = (amag + (AngW+2)'(1 << 16)) >> 17;
        a13 = aw_reg[AngW+1] ? -18'(signed'(amr[17:0])) : 18'(signed'(amr[17:0]));
        if (a13 <= -18'(Pi13)) a13 = a13 + 18'(TwoPi13);
        if (a13 > 18'(Pi13)) a13 = 18'(Pi13);
    end

    // post stage C: multiply
    logic signed [39:0] prod_reg;
    logic [SwW-1:0] sw_c_reg;
    logic [DistW-1:0] dist_c_reg;

    // post stage D: sum, round, saturate
    logic signed [40:0] sum;
    logic [40:0] smag;
    logic [40:0] smr;
    logic signed [21:0] colw;
    logic signed [ColW-1:0] col;
    always_comb
    begin
        sum = 41'(prod_reg) + 41'(signed'({1'b0, sw_c_reg, 20'd0}));
        smag = sum[40] ? $unsigned(-sum) : $unsigned(sum);
        smr = (smag + 41'(1 << 20)) >> 21;
        colw = sum[40] ? -22'(signed'(smr[21:0])) : 22'(signed'(smr[21:0]));
        if (colw > 22'sd32767) col = 16'sh7fff;
        else if (colw < -22'sd32768) col = 16'sh8000;
        else col = colw[ColW-1:0];
    end

    logic [ColW-1:0] col_reg;
    logic [DistW-1:0] dist_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            aw_reg <= ad;
            dist_a_reg <= rnd[DistW-1:0];
            a13_reg <= a13;
            dist_b_reg <= dist_a_reg;
            prod_reg <= 40'(a13_reg) * 40'(signed'({1'b0, cols_per_radian_reg}));
            sw_c_reg <= screen_width_reg;
            dist_c_reg <= dist_b_reg;
            col_reg <= col;
            dist_reg <= dist_c_reg;
        end
    end

    assign m_axis_tdata = {7'd0, dist_reg, col_reg};
endmodule

// ===== tb/ptsc_checker.sv =====
`timescale 1ns / 1ps
module ptsc_checker
    import ptsc_pkg::*;
#(
    parameter int STEPS = CordicStepsDefault
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [143:0]        s_axis_tdata,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [47:0]         m_axis_tdata,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output int                  errors,
    output int                  pending
);
    typedef struct {
        logic signed [ColW-1:0] column;
        logic [DistW-1:0]       distance;
    } proj_t;

    localparam longint ATAN_RAD30 [24] = '{
        843314856, 497837829, 263043836, 133525158,
        67021686, 33543515, 16775850, 8388437,
        4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767,
        16383, 8191, 4095, 2047,
        1023, 511, 255, 127
    };
    localparam longint PI_RAD30 = 64'd3373259426;
    localparam longint TWO_PI_RAD30 = 64'd6746518852;
    localparam longint HALF_PI_RAD30 = 64'd1686629713;
    localparam longint PI_Q13 = 25736;
    localparam longint TWO_PI_Q13 = 51472;

    logic [SwW-1:0]  width_q;
    logic [CprW-1:0] gain_q;
    proj_t           proj_q[$];

    function automatic longint round_away(longint v, int s);
        longint unsigned m;
        longint unsigned r;
        m = (v < 0) ? longint'(-v) : longint'(v);
        r = (m + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint vector_angle(longint yi, longint xi);
        longint x;
        longint y;
        longint z;
        longint t;
        longint xs;
        longint ys;
        int n;
        n = (STEPS < 24) ? STEPS : 24;
        if (xi == 0 && yi == 0)
            return 0;
        x = xi * (64'sd1 << 24);
        y = yi * (64'sd1 << 24);
        z = 0;
        // pre-rotate the left half plane by a quarter turn
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = HALF_PI_RAD30;
            end
            else
            begin
                x = -y;
                y = t;
                z = -HALF_PI_RAD30;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_RAD30[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_RAD30[i];
            end
        end
        return z;
    endfunction

    function automatic longint unsigned root_nearest(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        longint unsigned rem;
        r = 0;
        b = 64'd1 << 62;
        rem = v;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        if (rem > r)
            r++;
        return r;
    endfunction

    function automatic proj_t project(logic [143:0] d, logic [SwW-1:0] w, logic [CprW-1:0] g);
        proj_t  p;
        longint dx;
        longint dy;
        longint a;
        longint a13;
        longint sum;
        longint col;
        dx = longint'($signed(d[23:0])) - longint'($signed(d[71:48]));
        dy = longint'($signed(d[47:24])) - longint'($signed(d[95:72]));
        a = vector_angle(dy, dx)
            - vector_angle(longint'($signed(d[143:120])), longint'($signed(d[119:96])));
        if (a > PI_RAD30) a = a - TWO_PI_RAD30;
        if (a > PI_RAD30) a = a - TWO_PI_RAD30;
        if (a <= -PI_RAD30) a = a + TWO_PI_RAD30;
        if (a <= -PI_RAD30) a = a + TWO_PI_RAD30;
        a13 = round_away(a, 17);
        // keep the angle on (-pi, pi]
        if (a13 <= -PI_Q13) a13 = a13 + TWO_PI_Q13;
        if (a13 > PI_Q13) a13 = PI_Q13;
        sum = (longint'(w) << 20) + a13 * longint'(g);
        col = round_away(sum, 21);
        if (col > 32767) col = 32767;
        if (col < -32768) col = -32768;
        p.column = col[15:0];
        p.distance = DistW'(root_nearest(dx * dx + dy * dy));
        return p;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    assign pending = proj_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        proj_t want;
        if (!rst_n)
        begin
            width_q <= SwReset;
            gain_q <= CprReset;
            proj_q.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CfgScreenWidth)
                    width_q <= cfg_data[SwW-1:0];
                else if (cfg_index == CfgColsPerRadian)
                    gain_q <= cfg_data[CprW-1:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                proj_q.push_back(project(s_axis_tdata, width_q, gain_q));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (proj_q.size() == 0)
                    report_mismatch("unexpected result", m_axis_tdata[15:0], 0);
                else
                begin
                    want = proj_q.pop_front();
                    if (m_axis_tdata[15:0] !== want.column)
                        report_mismatch("column", $signed(m_axis_tdata[15:0]), want.column);
                    if (m_axis_tdata[40:16] !== want.distance)
                        report_mismatch("distance", m_axis_tdata[40:16], want.distance);
                end
            end
        end
    end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import ptsc_pkg::*;

    localparam int LATENCY = CordicStepsDefault + 5;
    localparam int STALL_LIMIT = 5000;
    localparam logic signed [23:0] FMAX = 24'sh7FFFFF;
    localparam logic signed [23:0] FMIN = -24'sh800000;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [143:0]        s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [47:0]         m_axis_tdata;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;
    int                  errors;
    int                  pending;
    int                  quiet_cycles;
    bit                  no_idle;

    point_to_screen_column_projection DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ptsc_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 33);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_point(logic signed [23:0] px, logic signed [23:0] py,
                              logic signed [23:0] vx, logic signed [23:0] vy,
                              logic signed [23:0] hx, logic signed [23:0] hy);
        if (!no_idle && $urandom_range(0, 99) < 33)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {hy, hx, vy, vx, py, px};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_view(logic [SwW-1:0] w, logic [CprW-1:0] g);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CfgScreenWidth;
        cfg_data <= CfgDataW'(w);
        @(posedge clk);
        cfg_index <= CfgColsPerRadian;
        cfg_data <= g;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [23:0] pick_edge();
        case ($urandom_range(0, 4))
            0: return FMAX;
            1: return FMIN;
            2: return 24'sd0;
            3: return 24'sd1;
            default: return -24'sd1;
        endcase
    endfunction

    function automatic logic signed [23:0] near(logic signed [23:0] base, int span);
        return base + 24'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic send_random;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        int mode;
        vx = 24'($urandom);
        vy = 24'($urandom);
        mode = $urandom_range(0, 9);
        if (mode <= 5)
            send_point(near(vx, 1 << 16), near(vy, 1 << 16), vx, vy,
                       near(24'sd0, 1 << 14), near(24'sd0, 1 << 14));
        else if (mode <= 7)
            send_point(24'($urandom), 24'($urandom), vx, vy,
                       24'($urandom), 24'($urandom));
        else if (mode == 8)
        begin
            if ($urandom_range(0, 1))
                send_point(vx, vy, vx, vy, 24'($urandom), 24'($urandom));
            else
                send_point(24'($urandom), 24'($urandom), vx, vy, 24'sd0, 24'sd0);
        end
        else
            send_point(pick_edge(), pick_edge(), pick_edge(), pick_edge(),
                       pick_edge(), pick_edge());
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = CfgScreenWidth;
        cfg_data = '0;
        no_idle = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings first
        send_point(FMAX, FMAX, FMIN, FMIN, 24'sd4096, 24'sd0);
        send_point(FMIN, FMIN, FMAX, FMAX, 24'sd0, 24'sd4096);
        send_point(FMAX, FMIN, FMIN, FMAX, FMIN, FMIN);
        send_point(24'sd100, 24'sd200, 24'sd100, 24'sd200, 24'sd4096, 24'sd0);
        send_point(24'sd4096, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
        send_point(24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
        // angle on the branch cut, both directions
        send_point(-24'sd4096, 24'sd0, 24'sd0, 24'sd0, 24'sd4096, 24'sd0);
        send_point(24'sd4096, 24'sd0, 24'sd0, 24'sd0, -24'sd4096, 24'sd0);
        send_point(24'sd4096, 24'sd0, 24'sd0, 24'sd0, -24'sd4096, -24'sd1);
        send_point(24'sd4096, -24'sd1, 24'sd0, 24'sd0, -24'sd4096, 24'sd0);
        send_point(24'sd0, -24'sd4096, 24'sd0, 24'sd0, 24'sd0, 24'sd4096);
        send_point(24'sd1, 24'sd1, 24'sd0, 24'sd0, -24'sd1, -24'sd1);
        // saturation of the column at high gain
        set_view(12'd4095, 20'hFFFFF);
        send_point(24'sd0, -24'sd4096, 24'sd0, 24'sd0, 24'sd4096, 24'sd0);
        send_point(24'sd0, 24'sd4096, 24'sd0, 24'sd0, 24'sd4096, 24'sd0);
        send_point(-24'sd4096, 24'sd1, 24'sd0, 24'sd0, 24'sd4096, 24'sd0);
        set_view(12'd0, 20'd0);
        send_point(24'sd0, 24'sd4096, 24'sd0, 24'sd0, 24'sd4096, 24'sd0);
        send_point(FMAX, FMIN, 24'sd5, 24'sd7, FMIN, FMAX);
        set_view(12'd1, 20'd1);
        send_point(24'sd0, 24'sd4096, 24'sd0, 24'sd0, 24'sd4096, 24'sd0);
        send_point(24'sd0, -24'sd4096, 24'sd0, 24'sd0, 24'sd4096, 24'sd0);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_view(SwReset, CprReset);
                1: set_view(12'd4095, 20'hFFFFF);
                2: set_view(12'd1, 20'd0);
                3: set_view(SwW'($urandom_range(1, 4095)),
                            CprW'($urandom_range(0, 20'hFFFFF)));
                4: set_view(12'd640, 20'd156468);
                default: set_view(SwW'($urandom_range(0, 4095)),
                                  CprW'($urandom_range(0, 20'hFFFFF)));
            endcase
            no_idle = (phase == 4);
            repeat (300) send_random();
        end

        drain();
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
